/* src/base64_stream_decoder_defines.svh */
// ----------------------------------------------------------------------------
// base64 stream decoder assertion macros
// shared concurrent assertion forms for the decoder modules
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define B64D_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define B64D_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// types, constants and the character map of the base64 stream decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

  // result codes
  typedef enum logic [1:0] {
    ST_BYTE       = 2'd0,
    ST_BAD_CHAR   = 2'd1,
    ST_SHORT_LINE = 2'd2
  } status_e;

  // one input transaction
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_line;
  } b64d_in_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] data_byte;
    status_e    status;
    logic       last;
  } b64d_out_t;

  localparam int MaxRes   = 3;             // results caused by one character
  localparam int QDepth   = 2 * MaxRes;    // result queue entries
  localparam int QCntW    = $clog2(QDepth + 1);
  localparam int SextetW  = 6;
  localparam int AccW     = 3 * SextetW;

  // results pushed by one accepted character
  typedef struct packed {
    logic [1:0]                n;
    b64d_out_t [MaxRes-1:0]    res;
  } b64d_push_t;

  // character codes
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5a;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7a;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChPad    = 8'h3d;

  // offsets that map a character range onto its sextet values
  localparam logic [7:0] OffUpper = 8'd65;   // 'A' -> 0
  localparam logic [7:0] OffLower = 8'd71;   // 'a' -> 26
  localparam logic [7:0] OffDigit = 8'd4;    // '0' -> 52, added

  localparam logic [5:0] SxPlus   = 6'd62;
  localparam logic [5:0] SxSlash  = 6'd63;

  // {invalid, sextet}; pad maps to zero
  function automatic logic [SextetW:0] sextet_of(input logic [7:0] c);
    logic [7:0] t;
    logic [SextetW:0] r;
    t = 8'd0;
    r = {1'b1, 6'd0};
    if (c >= ChUpperA && c <= ChUpperZ) begin
      t = c - OffUpper;
      r = {1'b0, t[5:0]};
    end else if (c >= ChLowerA && c <= ChLowerZ) begin
      t = c - OffLower;
      r = {1'b0, t[5:0]};
    end else if (c >= ChDigit0 && c <= ChDigit9) begin
      t = c + OffDigit;
      r = {1'b0, t[5:0]};
    end else if (c == ChPlus) begin
      r = {1'b0, SxPlus};
    end else if (c == ChSlash) begin
      r = {1'b0, SxSlash};
    end else if (c == ChPad) begin
      r = {1'b0, 6'd0};
    end
    return r;
  endfunction

endpackage

/* src/b64d_decode.sv */
// ----------------------------------------------------------------------------
// b64d_decode
// group state and result generation for one accepted character per cycle
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_defines.svh"

module b64d_decode import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  b64d_in_t   in_i,
  output b64d_push_t push_o
);

  logic [AccW-1:0]    acc_q, acc_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               bad_q, bad_d;
  logic               skip_q, skip_d;

  logic [SextetW:0]   sx;
  logic               bad;
  logic [AccW+5:0]    word;

  assign sx   = sextet_of(in_i.char_in);
  assign bad  = bad_q | sx[SextetW];
  assign word = {acc_q, sx[SextetW-1:0]};

  always_comb begin
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    bad_d  = bad_q;
    skip_d = skip_q;
    push_o = '0;
    if (accept_i) begin
      if (skip_q) begin
        // drop characters up to the line end
        if (in_i.end_of_line) begin
          skip_d = 1'b0;
          acc_d  = '0;
          cnt_d  = '0;
          bad_d  = 1'b0;
        end
      end else if (cnt_q == 2'd3) begin
        // fourth sextet closes the group
        acc_d = '0;
        cnt_d = '0;
        bad_d = 1'b0;
        if (bad) begin
          push_o.n                = 2'd1;
          push_o.res[0].data_byte = 8'd0;
          push_o.res[0].status    = ST_BAD_CHAR;
          push_o.res[0].last      = in_i.end_of_line;
          skip_d                  = ~in_i.end_of_line;
        end else begin
          push_o.n                = 2'd3;
          push_o.res[0].data_byte = word[23:16];
          push_o.res[0].status    = ST_BYTE;
          push_o.res[0].last      = 1'b0;
          push_o.res[1].data_byte = word[15:8];
          push_o.res[1].status    = ST_BYTE;
          push_o.res[1].last      = 1'b0;
          push_o.res[2].data_byte = word[7:0];
          push_o.res[2].status    = ST_BYTE;
          push_o.res[2].last      = in_i.end_of_line;
        end
      end else if (in_i.end_of_line) begin
        // line ends inside a group
        acc_d                   = '0;
        cnt_d                   = '0;
        bad_d                   = 1'b0;
        push_o.n                = 2'd1;
        push_o.res[0].data_byte = 8'd0;
        push_o.res[0].status    = bad ? ST_BAD_CHAR : ST_SHORT_LINE;
        push_o.res[0].last      = 1'b1;
      end else begin
        acc_d = {acc_q[AccW-SextetW-1:0], sx[SextetW-1:0]};
        cnt_d = cnt_q + 2'd1;
        bad_d = bad;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      bad_q  <= 1'b0;
      skip_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      bad_q  <= bad_d;
      skip_q <= skip_d;
    end
  end

  `B64D_ASSERT_IMP(a_skip_empty_group, clk_i, rst_ni, skip_q, cnt_q == 2'd0 && !bad_q, "skip with open group")
  `B64D_ASSERT_IMP(a_empty_group_clear, clk_i, rst_ni, cnt_q == 2'd0, acc_q == '0 && !bad_q, "stale group state")

endmodule

/* src/b64d_queue.sv */
// ----------------------------------------------------------------------------
// b64d_queue
// shifting result queue: takes up to three results, hands out one per ready cycle
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_defines.svh"

module b64d_queue import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  b64d_push_t push_i,
  output logic       space_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output b64d_out_t  out_data_o
);

  b64d_out_t [QDepth-1:0] ent_q, ent_d, shifted;
  logic [QCntW-1:0]       cnt_q, cnt_d, base_cnt;
  logic                   pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = ent_q[0];
  assign pop         = out_valid_o & out_ready_i;
  // room for the largest burst of one character
  assign space_o     = (cnt_q <= QCntW'(QDepth - MaxRes));
  assign base_cnt    = cnt_q - QCntW'(pop);
  assign cnt_d       = base_cnt + QCntW'(push_i.n);

  always_comb begin
    for (int i = 0; i < QDepth - 1; i++) begin
      shifted[i] = ent_q[i+1];
    end
    shifted[QDepth-1] = ent_q[QDepth-1];
  end

  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      ent_d[i] = pop ? shifted[i] : ent_q[i];
      for (int k = 0; k < MaxRes; k++) begin
        if (QCntW'(k) < QCntW'(push_i.n) && (base_cnt + QCntW'(k)) == QCntW'(i)) begin
          ent_d[i] = push_i.res[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  `B64D_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i.n != 2'd0, cnt_d <= QCntW'(QDepth), "result queue overflow")
  `B64D_ASSERT_NXT(a_count_track, clk_i, rst_ni, !pop, cnt_q == $past(cnt_q) + QCntW'($past(push_i.n)), "queue count mismatch")

endmodule

/* src/base64_stream_decoder.sv */
// ----------------------------------------------------------------------------
// base64 stream decoder
// line-oriented base64 decoder, one character in per cycle unless stalled, bytes out
// ----------------------------------------------------------------------------
// usage:
//   input channel  : in_valid_i / in_ready_o, payload in_data_i carries one
//                    character and its end-of-line mark per transaction
//   output channel : out_valid_o / out_ready_i, payload out_data_o carries
//                    one decoded byte or one error code per transaction
//   four characters form a group that yields three bytes, most significant
//   first; a bad group or a line that ends mid-group yields one error
//   transaction and the rest of that line is dropped
//   ordering       : a character's results enter the queue register when the
//                    character is taken and are offered in order, behind any
//                    results still queued
//   throughput     : one character per cycle unless stalled; the output side
//   drains one result per ready cycle from a six-entry queue, and the input
//   stalls only when that queue holds more than three results
//   reset          : clears the group, the skip flag and the queue; no result
//   is pending afterwards
//   receiver stall : results wait in the queue, input keeps flowing until
//   the queue cannot take another three-result burst
// ----------------------------------------------------------------------------
module base64_stream_decoder import b64d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  b64d_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output b64d_out_t out_data_o
);

  logic       accept;
  b64d_push_t push;

  // ready depends only on queue fill, never on the output handshake
  assign accept = in_valid_i & in_ready_o;

  // group tracking and result generation
  b64d_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .push_o   (push)
  );

  // result register stage, serializes bursts of up to three results
  b64d_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/sv/b64d_decode_checker.sv */
// ----------------------------------------------------------------------------
// b64d decode checker
// watches both channels of the base64 stream decoder, decodes every accepted
// character on its own and compares each accepted result in order
// ----------------------------------------------------------------------------
module b64d_decode_checker import b64d_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  b64d_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  b64d_out_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam int ReportLimit = 10;

  // decoder state
  logic [17:0] group_acc;
  logic [1:0]  group_len;
  logic        group_has_bad;
  logic        line_skip;

  b64d_out_t   decoded_queue[$];

  // {invalid, value}; pad counts as zero
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= "A" && c <= "Z") begin
      d = c - "A";
    end else if (c >= "a" && c <= "z") begin
      d = c - "a" + 8'd26;
    end else if (c >= "0" && c <= "9") begin
      d = c - "0" + 8'd52;
    end else if (c == "+") begin
      d = 8'd62;
    end else if (c == "/") begin
      d = 8'd63;
    end else if (c != "=") begin
      return {1'b1, 6'd0};
    end
    return {1'b0, d[5:0]};
  endfunction

  function automatic void push_result(input logic [7:0] b, input status_e st,
                                      input logic lst);
    b64d_out_t r;
    r.data_byte = b;
    r.status    = st;
    r.last      = lst;
    decoded_queue.push_back(r);
  endfunction

  function automatic void clear_group();
    group_acc     = '0;
    group_len     = '0;
    group_has_bad = 1'b0;
  endfunction

  function automatic void decode_char(input b64d_in_t t);
    logic [6:0]  sx;
    logic [23:0] word;
    logic        bad_now;
    if (line_skip) begin
      if (t.end_of_line) begin
        line_skip = 1'b0;
        clear_group();
      end
      return;
    end
    sx      = char_sextet(t.char_in);
    bad_now = group_has_bad | sx[6];
    if (group_len == 2'd3) begin
      word = {group_acc, sx[5:0]};
      if (bad_now) begin
        push_result(8'd0, ST_BAD_CHAR, t.end_of_line);
        clear_group();
        if (!t.end_of_line) line_skip = 1'b1;
      end else begin
        push_result(word[23:16], ST_BYTE, 1'b0);
        push_result(word[15:8], ST_BYTE, 1'b0);
        push_result(word[7:0], ST_BYTE, t.end_of_line);
        clear_group();
      end
    end else begin
      group_acc     = {group_acc[11:0], sx[5:0]};
      group_len     = group_len + 2'd1;
      group_has_bad = bad_now;
      if (t.end_of_line) begin
        push_result(8'd0, group_has_bad ? ST_BAD_CHAR : ST_SHORT_LINE, 1'b1);
        clear_group();
      end
    end
  endfunction

  always @(posedge clk_i) begin
    b64d_out_t want;
    if (!rst_ni) begin
      clear_group();
      line_skip    = 1'b0;
      decoded_queue.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) decode_char(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (decoded_queue.size() == 0) begin
          if (fail_count_o < ReportLimit)
            $display("unexpected result: byte %02h status %0d last %0b",
                     out_data_i.data_byte, out_data_i.status, out_data_i.last);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = decoded_queue.pop_front();
          if (want.data_byte !== out_data_i.data_byte ||
              want.status !== out_data_i.status ||
              want.last !== out_data_i.last) begin
            if (fail_count_o < ReportLimit)
              $display({"mismatch: expected byte %02h status %0d last %0b, ",
                        "got byte %02h status %0d last %0b"},
                       want.data_byte, want.status, want.last,
                       out_data_i.data_byte, out_data_i.status, out_data_i.last);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      pending_o = decoded_queue.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the base64 stream decoder: directed lines, then
// random lines under three idle mixes, a long receiver hold-off and drains
// ----------------------------------------------------------------------------
module tb_top import b64d_pkg::*;;

  localparam int WatchdogLimit = 4000;   // cycles with no transaction at all
  localparam int HoldCycles    = 120;    // long receiver hold-off
  localparam int DrainCycles   = 16;     // quiet cycles after the last result

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  b64d_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  b64d_out_t out_data;

  int fail_count;
  int pending;

  // idle mix, in percent of cycles
  int send_idle_pct = 18;
  int recv_idle_pct = 64;

  // long hold-off request, taken over by the receiver process
  bit hold_req = 1'b0;
  int hold_left = 0;

  int items_sent = 0;
  int idle_cycles = 0;

  always #6 clk_i = ~clk_i;

  base64_stream_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  b64d_decode_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver: random ready, or held low for a counted stretch on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: any transaction on either channel restarts the count
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // uniform pick from the base64 alphabet
  function automatic logic [7:0] random_b64_char();
    int idx;
    idx = $urandom_range(0, 63);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    if (idx == 62) return "+";
    return "/";
  endfunction

  // one input transaction; entered and left at a falling edge, so valid is
  // only ever written once per time step
  task automatic send_char(input logic [7:0] c, input logic eol);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= {c, eol};
    do @(posedge clk_i); while (!in_ready);
    items_sent = items_sent + 1;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input logic eol_at_end);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], eol_at_end && (i == s.len() - 1));
  endtask

  // sender pause: nothing offered until every expected result is out;
  // always leaves at a later falling edge than it entered
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // one random line: mostly whole groups, some short lines, some noise
  task automatic send_line();
    int kind;
    int n;
    int pads;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      // well-formed line, last group may carry one or two pad characters
      n    = 4 * $urandom_range(1, 4);
      pads = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
      for (int i = 0; i < n; i++) begin
        c = (i >= n - pads) ? 8'("=") : random_b64_char();
        send_char(c, i == n - 1);
      end
    end else if (kind < 85) begin
      // line that stops inside a group
      n = 4 * $urandom_range(0, 2) + $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        send_char(random_b64_char(), i == n - 1);
    end else begin
      // noise: any byte, dense around the printable ranges, stray line ends
      n = $urandom_range(1, 9);
      for (int i = 0; i < n; i++) begin
        c = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                 : 8'($urandom_range(8'h28, 8'h7b));
        send_char(c, (i == n - 1) || ($urandom_range(0, 15) == 0));
      end
    end
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct, input int n_items);
    int target;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    target = items_sent + n_items;
    while (items_sent < target) send_line();
    wait_drained();
  endtask

  initial begin
    // reset held low from the start, released at a falling edge
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed lines
    send_text("TWFu", 1'b1);             // plain group ending the line
    send_text("////", 1'b1);             // all ones
    send_text("QQ==", 1'b1);             // padding gives zero bytes
    send_text("QQ", 1'b1);               // line ends mid-group
    send_char("A", 1'b0);                // invalid byte inside a full group,
    send_char(8'hff, 1'b0);              // then the rest of the line is dropped
    send_text("AA", 1'b0);
    send_text("zz", 1'b1);
    send_char(8'h00, 1'b1);              // short group holding an invalid char
    send_text("AAA", 1'b0);              // bad full group closed by the line end
    send_char(8'h80, 1'b1);
    send_text("+/9", 1'b1);              // short group of valid chars
    wait_drained();

    // random lines under two of the idle mixes
    run_phase(18, 64, 45);
    run_phase(64, 18, 45);

    // no idling; a long receiver hold-off fills the block and stalls input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    run_phase(0, 0, 45);

    // end: everything out, then DrainCycles quiet cycles for stray results
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
